// ----- rtl/mrrs_pkg.sv -----
`default_nettype none
package mrrs_pkg;

	localparam int NUM_SLOTS_DEF   = 64;
	localparam int NUM_LEVELS_DEF  = 8;
	localparam int LEVEL_DEPTH_DEF = 32;

	localparam int IN_W  = 24;
	localparam int OUT_W = 24;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_SLEEP = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_NOSLOT = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;
	localparam logic [1:0] STAT_NORUN  = 2'd3;

	localparam logic [1:0] SLOT_FREE  = 2'd0;
	localparam logic [1:0] SLOT_SLEEP = 2'd1;
	localparam logic [1:0] SLOT_RUN   = 2'd2;

	typedef struct packed {
		logic wr;
		logic sh;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/mrrs_cell.sv -----
`default_nettype none
module mrrs_cell #(
	parameter int W = 6
) (
	input  wire logic               clk,
	input  wire mrrs_pkg::cell_ctl_t ctl,
	input  wire logic [W-1:0]       wdata,
	input  wire logic [W-1:0]       nbr,
	output logic [W-1:0]            q
);
	import mrrs_pkg::*;

	logic [W-1:0] val_q;

	// append wins over compaction; compaction pulls the right neighbor in
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			val_q <= wdata;
		end else if (ctl.sh) begin
			val_q <= nbr;
		end
	end

	assign q = val_q;

endmodule
`default_nettype wire

// ----- rtl/multilevel_round_robin_scheduler_top.sv -----
`default_nettype none
// Flow: alloc runs a slot scan (one slot a cycle); run and sleep do a slot table
// fetch, then a list search (one list cell a cycle).
// Throughput: one operation at a time; the next is taken once the result is
// in the output register, which a stalled sink may hold meanwhile.
// Reset: arst_n clears slot written flags, counts, cursors and control at once;
// the slot table and list cells need no clearing.
module multilevel_round_robin_scheduler_top #(
	parameter int NUM_SLOTS   = mrrs_pkg::NUM_SLOTS_DEF,
	parameter int NUM_LEVELS  = mrrs_pkg::NUM_LEVELS_DEF,
	parameter int LEVEL_DEPTH = mrrs_pkg::LEVEL_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	// opcode[1:0], task_id[7:2], target_level[10:8], keep_level[11],
	// slice_ticks[19:12], zero[23:20]
	input  wire logic [mrrs_pkg::IN_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	// status[1:0], allocated_task[7:2], current_task[13:8], switched[14],
	// load_timer[15], time_slice[23:16]
	output logic [mrrs_pkg::OUT_W-1:0]    m_tdata
);
	import mrrs_pkg::*;

	localparam int SW  = $clog2(NUM_SLOTS);
	localparam int LW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int IW  = $clog2(LEVEL_DEPTH);
	localparam int CNW = $clog2(LEVEL_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_ALLOC, S_FETCH, S_RUN, S_SLEEP, S_FIND, S_SHIFT, S_APPEND,
		S_SLPRES, S_TICK, S_CUR, S_OUT
	} state_t;

	typedef struct packed {
		logic [7:0]    slice;
		logic [LW-1:0] level;
		logic [1:0]    status;
	} slot_word_t;

	state_t state_q;

	logic [1:0]    op_q;
	logic [5:0]    task_q;
	logic [2:0]    tlv_q;
	logic          keep_q;
	logic [7:0]    slice_q;
	logic [7:0]    wslice_q;
	logic [1:0]    status_q;
	logic [5:0]    alloc_q;
	logic [SW-1:0] a_q;
	logic [CNW-1:0] i_q;
	logic [IW-1:0] pos_q;
	logic [LW-1:0] rm_lv_q;
	logic [LW-1:0] ap_lv_q;
	logic          had_q;
	logic [SW-1:0] old_q;
	logic          resel_q;
	logic          have_q;
	logic [SW-1:0] cur_q;

	slot_word_t     slot_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] slot_vld_q;
	slot_word_t     slot_rd_q;
	logic           slot_rd_vld_q;
	logic [CNW-1:0] count_q  [NUM_LEVELS];
	logic [IW-1:0]  cursor_q [NUM_LEVELS];
	logic [LW-1:0]  active_q;
	logic           dirty_q;

	logic               m_valid_q;
	logic [OUT_W-1:0]   m_data_q;

	logic [SW-1:0] member_w [NUM_LEVELS][LEVEL_DEPTH];

	logic [SW-1:0]  tslot;
	logic           tin;
	logic [SW-1:0]  sl_addr;
	logic [1:0]     sl_status;
	logic [LW-1:0]  sl_level;
	logic [7:0]     sl_slice;
	logic           slot_we;
	logic [SW-1:0]  slot_waddr;
	slot_word_t     slot_wdata;
	logic [LW-1:0]  mem_lv;
	logic [IW-1:0]  mem_idx;
	logic [SW-1:0]  mem_rd;
	logic           cur_valid;
	logic [LW-1:0]  tlv_c;
	logic [LW-1:0]  run_lv;
	logic           on_level;
	logic           full;
	logic [LW-1:0]  sel_lv;
	logic [CNW-1:0] tick_nxt;
	logic [CNW-1:0] sh_cnt;
	logic [IW-1:0]  sh_cur;
	logic [1:0]     r_status;
	logic           r_sw;
	logic           r_load;
	logic [5:0]     r_cur;
	logic [7:0]     r_slice;
	state_t         after_take;

	assign tslot = SW'(int'(task_q));
	assign tin   = int'(task_q) < NUM_SLOTS;

	// read address for the next cycle's slot word
	always_comb begin
		unique case (state_q)
			S_CUR:   sl_addr = mem_rd;
			S_OUT:   sl_addr = cur_q;
			default: sl_addr = tslot;
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_q[slot_waddr] <= slot_wdata;
		end
		slot_rd_q     <= slot_q[sl_addr];
		slot_rd_vld_q <= slot_vld_q[sl_addr];
	end

	// never-written slots read as free, level 0, slice 0
	assign sl_status = slot_rd_vld_q ? slot_rd_q.status : SLOT_FREE;
	assign sl_level  = slot_rd_vld_q ? slot_rd_q.level  : '0;
	assign sl_slice  = slot_rd_vld_q ? slot_rd_q.slice  : 8'd0;

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = tslot;
		slot_wdata = '0;
		unique case (state_q)
			S_ALLOC: begin
				slot_we           = !slot_vld_q[a_q];
				slot_waddr        = a_q;
				slot_wdata.status = SLOT_SLEEP;
			end
			S_RUN: begin
				slot_we           = tin && on_level && (slice_q != 8'd0);
				slot_wdata.slice  = slice_q;
				slot_wdata.level  = sl_level;
				slot_wdata.status = sl_status;
			end
			S_FIND: begin
				slot_we           = i_q >= count_q[rm_lv_q];
				slot_wdata.slice  = wslice_q;
				slot_wdata.level  = rm_lv_q;
				slot_wdata.status = SLOT_SLEEP;
			end
			S_SHIFT: begin
				slot_we           = 1'b1;
				slot_wdata.slice  = wslice_q;
				slot_wdata.level  = rm_lv_q;
				slot_wdata.status = SLOT_SLEEP;
			end
			S_APPEND: begin
				slot_we           = 1'b1;
				slot_wdata.slice  = wslice_q;
				slot_wdata.level  = ap_lv_q;
				slot_wdata.status = SLOT_RUN;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (state_q == S_FIND) begin
			mem_lv  = rm_lv_q;
			mem_idx = i_q[IW-1:0];
		end else begin
			mem_lv  = active_q;
			mem_idx = cursor_q[active_q];
		end
	end

	assign mem_rd    = member_w[mem_lv][mem_idx];
	assign cur_valid = (count_q[active_q] != '0) &&
		(CNW'(cursor_q[active_q]) < count_q[active_q]);

	assign tlv_c    = (int'(tlv_q) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1) : LW'(int'(tlv_q));
	assign run_lv   = keep_q ? sl_level : tlv_c;
	assign on_level = (sl_status == SLOT_RUN) && (sl_level == run_lv);
	assign full     = count_q[run_lv] >= CNW'(LEVEL_DEPTH);

	// lowest non-empty level, 0 when all are empty
	always_comb begin
		sel_lv = '0;
		for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
			if (count_q[l] != '0) begin
				sel_lv = LW'(l);
			end
		end
	end

	always_comb begin
		tick_nxt = CNW'(cursor_q[active_q]) + CNW'(1);
		if (count_q[active_q] == '0 || tick_nxt >= count_q[active_q]) begin
			tick_nxt = '0;
		end
	end

	always_comb begin
		sh_cnt = count_q[rm_lv_q] - CNW'(1);
		sh_cur = cursor_q[rm_lv_q];
		if (pos_q < sh_cur) begin
			sh_cur = sh_cur - IW'(1);
		end
		if (CNW'(sh_cur) >= sh_cnt) begin
			sh_cur = '0;
		end
	end

	assign after_take = (op_q == OP_RUN) ? S_APPEND : S_SLPRES;

	always_comb begin
		r_status = status_q;
		r_sw     = 1'b0;
		r_load   = 1'b0;
		if (op_q == OP_TICK) begin
			r_status = have_q ? STAT_OK : STAT_NORUN;
			r_load   = have_q;
			r_sw     = have_q && (!had_q || cur_q != old_q);
		end else if (op_q == OP_SLEEP && resel_q) begin
			r_status = have_q ? STAT_OK : STAT_NORUN;
			r_sw     = have_q;
		end
		r_cur   = have_q ? 6'(int'(cur_q)) : 6'd0;
		r_slice = have_q ? sl_slice : 8'd0;
	end

	// list cells: one row per level
	for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_lv
		for (genvar d = 0; d < LEVEL_DEPTH; d++) begin : g_cell
			cell_ctl_t    ctl;
			logic [SW-1:0] nbr;
			assign ctl.wr = (state_q == S_APPEND) && (ap_lv_q == LW'(l)) &&
				(count_q[l] == CNW'(d));
			assign ctl.sh = (state_q == S_SHIFT) && (rm_lv_q == LW'(l)) &&
				(IW'(d) >= pos_q);
			if (d < LEVEL_DEPTH - 1) begin : g_nb
				assign nbr = member_w[l][d+1];
			end else begin : g_end
				assign nbr = '0;
			end
			mrrs_cell #(.W(SW)) u_cell (
				.clk   (clk),
				.ctl   (ctl),
				.wdata (tslot),
				.nbr   (nbr),
				.q     (member_w[l][d])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			active_q  <= '0;
			dirty_q   <= 1'b0;
			op_q      <= OP_ALLOC;
			task_q    <= '0;
			tlv_q     <= '0;
			keep_q    <= 1'b0;
			slice_q   <= '0;
			wslice_q  <= '0;
			status_q  <= STAT_OK;
			alloc_q   <= '0;
			a_q       <= '0;
			i_q       <= '0;
			pos_q     <= '0;
			rm_lv_q   <= '0;
			ap_lv_q   <= '0;
			had_q     <= 1'b0;
			old_q     <= '0;
			resel_q   <= 1'b0;
			have_q    <= 1'b0;
			cur_q     <= '0;
			slot_vld_q <= '0;
			for (int l = 0; l < NUM_LEVELS; l++) begin
				count_q[l]  <= '0;
				cursor_q[l] <= '0;
			end
		end else begin
			if (slot_we) begin
				slot_vld_q[slot_waddr] <= 1'b1;
			end
			if (state_q == S_OUT && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
				m_data_q  <= {r_slice, r_load, r_sw, r_cur, alloc_q, r_status};
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q     <= s_tdata[1:0];
						task_q   <= s_tdata[7:2];
						tlv_q    <= s_tdata[10:8];
						keep_q   <= s_tdata[11];
						slice_q  <= s_tdata[19:12];
						status_q <= STAT_OK;
						alloc_q  <= '0;
						resel_q  <= 1'b0;
						had_q    <= 1'b0;
						a_q      <= '0;
						unique case (s_tdata[1:0])
							OP_ALLOC: state_q <= S_ALLOC;
							OP_RUN:   state_q <= S_FETCH;
							OP_SLEEP: state_q <= S_FETCH;
							default:  state_q <= S_TICK;
						endcase
					end
				end
				S_ALLOC: begin
					if (!slot_vld_q[a_q]) begin
						alloc_q <= 6'(int'(a_q));
						state_q <= S_CUR;
					end else if (a_q == SW'(NUM_SLOTS - 1)) begin
						status_q <= STAT_NOSLOT;
						state_q  <= S_CUR;
					end else begin
						a_q <= a_q + SW'(1);
					end
				end
				// wait for the slot word of task_q
				S_FETCH: begin
					state_q <= (op_q == OP_RUN) ? S_RUN : S_SLEEP;
				end
				S_RUN: begin
					if (!tin) begin
						state_q <= S_CUR;
					end else if (!on_level && full) begin
						status_q <= STAT_FULL;
						state_q  <= S_CUR;
					end else begin
						wslice_q <= (slice_q != 8'd0) ? slice_q : sl_slice;
						dirty_q  <= 1'b1;
						ap_lv_q  <= run_lv;
						if (on_level) begin
							state_q <= S_CUR;
						end else if (sl_status == SLOT_RUN) begin
							rm_lv_q <= sl_level;
							i_q     <= '0;
							state_q <= S_FIND;
						end else begin
							state_q <= S_APPEND;
						end
					end
				end
				S_SLEEP: begin
					if (!tin || sl_status != SLOT_RUN) begin
						state_q <= S_CUR;
					end else begin
						had_q    <= cur_valid;
						old_q    <= mem_rd;
						rm_lv_q  <= sl_level;
						wslice_q <= sl_slice;
						i_q      <= '0;
						state_q  <= S_FIND;
					end
				end
				S_FIND: begin
					if (i_q >= count_q[rm_lv_q]) begin
						state_q <= after_take;
					end else if (mem_rd == tslot) begin
						pos_q   <= i_q[IW-1:0];
						state_q <= S_SHIFT;
					end else begin
						i_q <= i_q + CNW'(1);
					end
				end
				S_SHIFT: begin
					count_q[rm_lv_q]  <= sh_cnt;
					cursor_q[rm_lv_q] <= sh_cur;
					state_q <= after_take;
				end
				S_APPEND: begin
					count_q[ap_lv_q] <= count_q[ap_lv_q] + CNW'(1);
					state_q <= S_CUR;
				end
				S_SLPRES: begin
					if (had_q && old_q == tslot) begin
						active_q <= sel_lv;
						dirty_q  <= 1'b0;
						resel_q  <= 1'b1;
					end
					state_q <= S_CUR;
				end
				S_TICK: begin
					had_q <= cur_valid;
					old_q <= mem_rd;
					cursor_q[active_q] <= tick_nxt[IW-1:0];
					if (dirty_q) begin
						active_q <= sel_lv;
						dirty_q  <= 1'b0;
					end
					state_q <= S_CUR;
				end
				S_CUR: begin
					have_q  <= cur_valid;
					cur_q   <= mem_rd;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_valid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
`default_nettype wire

// ----- rtl/mrrs_checker.sv -----
`default_nettype none
module mrrs_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      m_tvalid,
	input wire logic                      m_tready,
	input wire logic [mrrs_pkg::OUT_W-1:0] m_tdata
);
	import mrrs_pkg::*;

	// hold a stalled transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_noslot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == STAT_NOSLOT |-> m_tdata[7:2] == 6'd0)
		else $error("failed alloc reports a slot");

	a_norun: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == STAT_NORUN |->
			m_tdata[13:8] == 6'd0 && !m_tdata[14] && !m_tdata[15] &&
			m_tdata[23:16] == 8'd0)
		else $error("no runnable task but a task is reported");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15] |-> m_tdata[1:0] == STAT_OK)
		else $error("timer reload with bad status");

endmodule

bind multilevel_round_robin_scheduler_top mrrs_checker u_mrrs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
